// ----- design/affine_bilinear_patch_sampler_top_assert.svh -----
// assertion macros for the affine bilinear patch sampler
`ifndef AFFINE_BILINEAR_PATCH_SAMPLER_TOP_ASSERT_SVH
`define AFFINE_BILINEAR_PATCH_SAMPLER_TOP_ASSERT_SVH

// clocked assertion held off while reset is active
`define ABPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("abps assertion failed");

// clocked assertion checked during reset too
`define ABPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("abps assertion failed");

`endif

// ----- design/abps_pkg.sv -----
// shared constants and types of the affine bilinear patch sampler
package abps_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int PATCH_DIM  = 256;
  localparam int COORD_W    = $clog2(PATCH_DIM);
  localparam int HALF_W     = COORD_W - 1;
  localparam int BANK_AW    = 2 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int COEF_W     = 18;
  localparam int REL_W      = 9;
  localparam int PIX_W      = 8;
  localparam int PROD_W     = COEF_W + REL_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int WHOLE_W    = SUM_W - FRAC_BITS;
  localparam int WGT_W      = FRAC_BITS + 1;
  localparam int HSUM_W     = PIX_W + WGT_W + 1;
  localparam int ACC_W      = HSUM_W + WGT_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XY  = 3'd0,
    REG_COEF_XX  = 3'd1,
    REG_COEF_YY  = 3'd2,
    REG_COEF_YX  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    logic               is_sample;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
    logic [REL_W-1:0]   rel_x;
    logic [REL_W-1:0]   rel_y;
  } item_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } queue_ctl_t;

endpackage

// ----- design/abps_front.sv -----
// front end: accepts requests, classifies them and queues them for the back end
module abps_front import abps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [COORD_W-1:0] load_row_i,
  input  logic [COORD_W-1:0] load_col_i,
  input  logic [PIX_W-1:0]   load_pixel_i,
  input  logic [REL_W-1:0]   rel_x_i,
  input  logic [REL_W-1:0]   rel_y_i,
  input  logic               pop_i,
  output queue_ctl_t         head_o,
  output item_t              item_o
);

  item_t       fifo_q [FIFO_DEPTH];
  logic        rd_ptr_q, rd_ptr_d;
  logic        wr_ptr_q, wr_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  item_t       in_item;

  always_comb begin
    in_item.is_sample = (op_e'(opcode_i) == OP_SAMPLE);
    in_item.row       = load_row_i;
    in_item.col       = load_col_i;
    in_item.pixel     = load_pixel_i;
    in_item.rel_x     = rel_x_i;
    in_item.rel_y     = rel_y_i;
  end

  assign in_ready_o = (cnt_q != 2'(FIFO_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_comb begin
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.pop   = pop;
  assign item_o       = fifo_q[rd_ptr_q];

endmodule

// ----- design/abps_back.sv -----
// back end: coordinate mapping, banked patch memory and bilinear weighting
module abps_back import abps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  queue_ctl_t            head_i,
  input  item_t                 item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      sample_value_o,
  output logic                  in_range_o
);

  localparam logic [WHOLE_W-1:0] MaxBase = WHOLE_W'(PATCH_DIM - 2);
  localparam logic [WGT_W-1:0]   OneW    = WGT_W'(1) << FRAC_BITS;

  logic signed [COEF_W-1:0] coef_xy_q, coef_xx_q, coef_yy_q, coef_yx_q;
  logic [COORD_W-1:0]       offset_x_q, offset_y_q;

  logic adv;

  // stage 1: products
  logic                     s1_valid_q;
  item_t                    s1_item_q;
  logic signed [PROD_W-1:0] p_xx_q, p_xy_q, p_yx_q, p_yy_q;
  // stage 2: coordinates
  logic                 s2_valid_q;
  item_t                s2_item_q;
  logic [COORD_W-1:0]   x0_q, y0_q;
  logic [FRAC_BITS-1:0] s2_fx_q, s2_fy_q;
  logic                 s2_inr_q;
  // stage 3: memory data
  logic                 s3_valid_q, s3_sample_q, s3_inr_q, s3_xb_q, s3_yb_q;
  logic [FRAC_BITS-1:0] s3_fx_q, s3_fy_q;
  logic [PIX_W-1:0]     rd_q [4];
  // stage 4: row blends
  logic                 s4_valid_q, s4_sample_q, s4_inr_q;
  logic [FRAC_BITS-1:0] s4_fx_q;
  logic [HSUM_W-1:0]    a0_q, a1_q;
  // output register
  logic                 out_valid_q, out_inr_q;
  logic [PIX_W-1:0]     out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xy_q  <= COEF_W'(16384);
      coef_xx_q  <= '0;
      coef_yy_q  <= '0;
      coef_yx_q  <= COEF_W'(16384);
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_XY:  coef_xy_q  <= cfg_data_i;
        REG_COEF_XX:  coef_xx_q  <= cfg_data_i;
        REG_COEF_YY:  coef_yy_q  <= cfg_data_i;
        REG_COEF_YX:  coef_yx_q  <= cfg_data_i;
        REG_OFFSET_X: offset_x_q <= cfg_data_i[COORD_W-1:0];
        REG_OFFSET_Y: offset_y_q <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves together unless a result is stuck at the output
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= head_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q && s4_sample_q;
    end
  end

  // stage 1
  logic signed [REL_W:0] rx_s, ry_s;
  assign rx_s = signed'({1'b0, item_i.rel_x});
  assign ry_s = signed'({1'b0, item_i.rel_y});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q <= item_i;
      p_xx_q    <= PROD_W'(coef_xx_q * rx_s);
      p_xy_q    <= PROD_W'(coef_xy_q * ry_s);
      p_yx_q    <= PROD_W'(coef_yx_q * rx_s);
      p_yy_q    <= PROD_W'(coef_yy_q * ry_s);
    end
  end

  // stage 2
  logic signed [SUM_W-1:0] off_x_s, off_y_s, px, py;
  logic                    inr_x, inr_y;

  always_comb begin
    off_x_s = signed'(SUM_W'({offset_x_q, FRAC_BITS'(0)}));
    off_y_s = signed'(SUM_W'({offset_y_q, FRAC_BITS'(0)}));
    px      = SUM_W'(p_xx_q) + SUM_W'(p_xy_q) + off_x_s;
    py      = SUM_W'(p_yx_q) + SUM_W'(p_yy_q) + off_y_s;
    // floor must be non negative and leave room for floor plus one
    inr_x   = !px[SUM_W-1] && (px[SUM_W-1:FRAC_BITS] <= MaxBase);
    inr_y   = !py[SUM_W-1] && (py[SUM_W-1:FRAC_BITS] <= MaxBase);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_item_q <= s1_item_q;
      x0_q      <= px[FRAC_BITS +: COORD_W];
      y0_q      <= py[FRAC_BITS +: COORD_W];
      s2_fx_q   <= px[FRAC_BITS-1:0];
      s2_fy_q   <= py[FRAC_BITS-1:0];
      s2_inr_q  <= inr_x && inr_y;
    end
  end

  // stage 3: four banks by row and column parity, so each neighbor has its own bank
  logic [BANK_AW-1:0] rd_addr [4];
  logic [BANK_AW-1:0] wr_addr;
  logic [3:0]         wr_en;
  logic [COORD_W-1:0] x1, y1;

  always_comb begin
    x1      = x0_q + COORD_W'(1);
    y1      = y0_q + COORD_W'(1);
    wr_addr = {s2_item_q.row[COORD_W-1:1], s2_item_q.col[COORD_W-1:1]};
    for (int b = 0; b < 4; b++) begin
      logic [COORD_W-1:0] r, c;
      r = (x0_q[0] == b[1]) ? x0_q : x1;
      c = (y0_q[0] == b[0]) ? y0_q : y1;
      rd_addr[b] = {r[COORD_W-1:1], c[COORD_W-1:1]};
      wr_en[b]   = adv && s2_valid_q && !s2_item_q.is_sample &&
                   ({s2_item_q.row[0], s2_item_q.col[0]} == b[1:0]);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem_q [BANK_DEPTH];
    always_ff @(posedge clk_i) begin
      if (wr_en[b]) begin
        mem_q[wr_addr] <= s2_item_q.pixel;
      end
      if (adv) begin
        rd_q[b] <= mem_q[rd_addr[b]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_sample_q <= s2_item_q.is_sample;
      s3_inr_q    <= s2_inr_q;
      s3_xb_q     <= x0_q[0];
      s3_yb_q     <= y0_q[0];
      s3_fx_q     <= s2_fx_q;
      s3_fy_q     <= s2_fy_q;
    end
  end

  // stage 4
  logic [PIX_W-1:0] p00, p01, p10, p11;
  logic [WGT_W-1:0] fy_w, gy_w;

  always_comb begin
    p00  = rd_q[{s3_xb_q, s3_yb_q}];
    p01  = rd_q[{s3_xb_q, ~s3_yb_q}];
    p10  = rd_q[{~s3_xb_q, s3_yb_q}];
    p11  = rd_q[{~s3_xb_q, ~s3_yb_q}];
    fy_w = WGT_W'(s3_fy_q);
    gy_w = OneW - fy_w;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_sample_q <= s3_sample_q;
      s4_inr_q    <= s3_inr_q;
      s4_fx_q     <= s3_fx_q;
      a0_q        <= HSUM_W'(p00 * gy_w) + HSUM_W'(p01 * fy_w);
      a1_q        <= HSUM_W'(p10 * gy_w) + HSUM_W'(p11 * fy_w);
    end
  end

  // stage 5: column blend and truncation
  logic [WGT_W-1:0] fx_w, gx_w;
  logic [ACC_W-1:0] acc;

  always_comb begin
    fx_w = WGT_W'(s4_fx_q);
    gx_w = OneW - fx_w;
    acc  = ACC_W'(a0_q * gx_w) + ACC_W'(a1_q * fx_w);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_inr_q <= s4_inr_q;
      out_val_q <= s4_inr_q ? acc[2*FRAC_BITS +: PIX_W] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_val_q;
  assign in_range_o     = out_inr_q;

endmodule

// ----- design/affine_bilinear_patch_sampler_top.sv -----
// A request passes a queue slot and 5 back stages before its result is offered.
// Throughput: one request per cycle, loads and samples alike, while the output is not stalled;
// loads give no result. The rate is set by four parity banks of patch memory, one read port each.
// Reset clears the queue, the pipeline valid bits and the registers to their defaults.
// Patch memory is not cleared: pixels are undefined until loaded, no clearing pass.
module affine_bilinear_patch_sampler_top import abps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [COORD_W-1:0]    load_row_i,
  input  logic [COORD_W-1:0]    load_col_i,
  input  logic [PIX_W-1:0]      load_pixel_i,
  input  logic [REL_W-1:0]      rel_x_i,
  input  logic [REL_W-1:0]      rel_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      sample_value_o,
  output logic                  in_range_o
);

  queue_ctl_t head;
  item_t      item;
  logic       pop;

  assign cfg_ready_o = 1'b1;

  abps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .load_row_i   (load_row_i),
    .load_col_i   (load_col_i),
    .load_pixel_i (load_pixel_i),
    .rel_x_i      (rel_x_i),
    .rel_y_i      (rel_y_i),
    .pop_i        (pop),
    .head_o       (head),
    .item_o       (item)
  );

  abps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .head_i         (head),
    .item_i         (item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o),
    .in_range_o     (in_range_o)
  );

endmodule

// ----- design/abps_checker.sv -----
// port level checks of the patch sampler and their binding
`include "affine_bilinear_patch_sampler_top_assert.svh"

module abps_checker import abps_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] sample_value_o,
  input logic             in_range_o
);

  // a stalled result keeps its value
  `ABPS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_value_o) && $stable(in_range_o))
  // an out of range sample reports zero
  `ABPS_ASSERT(a_oor_zero, clk_i, rst_ni, out_valid_o && !in_range_o |-> sample_value_o == '0)
  // the input only backs up after a result was held at the output
  `ABPS_ASSERT(a_in_stall_cause, clk_i, rst_ni, in_valid_i && !in_ready_o |-> $past(out_valid_o && !out_ready_i))
  // nothing is shown while reset is held
  `ABPS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind affine_bilinear_patch_sampler_top abps_checker u_abps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_value_o (sample_value_o),
  .in_range_o     (in_range_o)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the affine bilinear patch sampler
`timescale 1ns / 1ps

module testbench;
  import abps_pkg::*;

  localparam longint ONE_FX = longint'(1) << FRAC_BITS;
  localparam int LIMIT_CYCLES = 600000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    op_e         op;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  pixel;
    logic [8:0]  rx;
    logic [8:0]  ry;
  } request_t;

  typedef struct {
    logic [7:0] value;
    logic       in_range;
  } pixel_res_t;

  typedef struct {
    longint cxy, cxx, cyy, cyx, ox, oy;
  } warp_cfg_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i = 1'b0;
  logic [COORD_W-1:0]    load_row_i = '0;
  logic [COORD_W-1:0]    load_col_i = '0;
  logic [PIX_W-1:0]      load_pixel_i = '0;
  logic [REL_W-1:0]      rel_x_i = '0;
  logic [REL_W-1:0]      rel_y_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      sample_value_o;
  logic                  in_range_o;

  affine_bilinear_patch_sampler_top u_top (.*);

  request_t   pending_reqs[$];
  pixel_res_t expected_pixels[$];
  logic [7:0] patch_model [0:65535];
  bit         gen_written [0:65535];
  warp_cfg_t  model_cfg, gen_cfg;

  int  sender_idle_pct = 0;
  int  stall_pct = 0;
  bit  pressure_on = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  bit  in_taken = 1'b0;
  int  errors = 0;
  int  cycles = 0;
  int  n_loads = 0, n_samples = 0, n_hits = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void map_coord(input warp_cfg_t c, input longint rx, input longint ry,
                                    output longint x0, output longint fx,
                                    output longint y0, output longint fy);
    longint px, py;
    px = c.cxx * rx + c.cxy * ry + c.ox * ONE_FX;
    py = c.cyx * rx + c.cyy * ry + c.oy * ONE_FX;
    x0 = px >>> FRAC_BITS;
    y0 = py >>> FRAC_BITS;
    fx = px & (ONE_FX - 1);
    fy = py & (ONE_FX - 1);
  endfunction

  function automatic bit pair_inside(input longint c);
    return c >= 0 && c <= PATCH_DIM - 2;
  endfunction

  function automatic void apply_cfg(inout warp_cfg_t c, input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_COEF_XY:  c.cxy = longint'($signed(d));
      REG_COEF_XX:  c.cxx = longint'($signed(d));
      REG_COEF_YY:  c.cyy = longint'($signed(d));
      REG_COEF_YX:  c.cyx = longint'($signed(d));
      REG_OFFSET_X: c.ox = longint'(d[7:0]);
      REG_OFFSET_Y: c.oy = longint'(d[7:0]);
      default: ;
    endcase
  endfunction

  function automatic void predict_request(input request_t r);
    longint x0, y0, fx, fy, gx, gy, acc;
    pixel_res_t e;
    if (r.op == OP_LOAD) begin
      patch_model[{r.row, r.col}] = r.pixel;
      n_loads++;
    end else begin
      map_coord(model_cfg, r.rx, r.ry, x0, fx, y0, fy);
      n_samples++;
      if (!pair_inside(x0) || !pair_inside(y0)) begin
        e.value = '0;
        e.in_range = 1'b0;
      end else begin
        gx = ONE_FX - fx;
        gy = ONE_FX - fy;
        acc = longint'(patch_model[x0 * PATCH_DIM + y0]) * gx * gy
            + longint'(patch_model[x0 * PATCH_DIM + y0 + 1]) * gx * fy
            + longint'(patch_model[(x0 + 1) * PATCH_DIM + y0]) * fx * gy
            + longint'(patch_model[(x0 + 1) * PATCH_DIM + y0 + 1]) * fx * fy;
        e.value = 8'(acc >> (2 * FRAC_BITS));
        e.in_range = 1'b1;
        n_hits++;
      end
      expected_pixels.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic add_load(input logic [7:0] r, input logic [7:0] c, input logic [7:0] p);
    request_t q;
    q.op = OP_LOAD; q.row = r; q.col = c; q.pixel = p;
    q.rx = 9'($urandom); q.ry = 9'($urandom);
    pending_reqs.push_back(q);
    gen_written[{r, c}] = 1'b1;
  endtask

  // loads any neighbour not yet written so the sample never reads an unknown pixel
  task automatic add_sample(input logic [8:0] rx, input logic [8:0] ry);
    longint x0, y0, fx, fy;
    request_t q;
    map_coord(gen_cfg, rx, ry, x0, fx, y0, fy);
    if (pair_inside(x0) && pair_inside(y0)) begin
      for (int dr = 0; dr < 2; dr++) begin
        for (int dc = 0; dc < 2; dc++) begin
          if (!gen_written[(x0 + dr) * PATCH_DIM + y0 + dc])
            add_load(8'(x0 + dr), 8'(y0 + dc), 8'($urandom));
        end
      end
    end
    q.op = OP_SAMPLE; q.rx = rx; q.ry = ry;
    q.row = 8'($urandom); q.col = 8'($urandom); q.pixel = 8'($urandom);
    pending_reqs.push_back(q);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_cfg(gen_cfg, idx, d);
  endtask

  task automatic release_cfg();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_pixels.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic random_cfg(input int span);
    write_reg(REG_COEF_XY, 18'($signed($urandom_range(2 * span)) - span));
    write_reg(REG_COEF_XX, 18'($signed($urandom_range(2 * span)) - span));
    write_reg(REG_COEF_YY, 18'($signed($urandom_range(2 * span)) - span));
    write_reg(REG_COEF_YX, 18'($signed($urandom_range(2 * span)) - span));
    write_reg(REG_OFFSET_X, {10'($urandom), 8'($urandom_range(160, 96))});
    write_reg(REG_OFFSET_Y, {10'($urandom), 8'($urandom_range(160, 96))});
    release_cfg();
  endtask

  task automatic random_traffic(input int count);
    int start;
    start = pending_reqs.size();
    while (pending_reqs.size() - start < count) begin
      if ($urandom_range(99) < 70)
        add_sample(9'($urandom), 9'($urandom));
      else
        add_load(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    request_t r;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        r = pending_reqs.pop_front();
        in_valid_i   <= 1'b1;
        opcode_i     <= r.op;
        load_row_i   <= r.row;
        load_col_i   <= r.col;
        load_pixel_i <= r.pixel;
        rel_x_i      <= r.rx;
        rel_y_i      <= r.ry;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni)
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    request_t r;
    pixel_res_t e;
    cycles <= cycles + 1;
    in_taken <= in_valid_i && in_ready_o;
    if (cfg_valid_i && cfg_ready_o)
      apply_cfg(model_cfg, cfg_index_i, cfg_data_i);
    if (in_valid_i && in_ready_o) begin
      r.op = op_e'(opcode_i); r.row = load_row_i; r.col = load_col_i;
      r.pixel = load_pixel_i; r.rx = rel_x_i; r.ry = rel_y_i;
      predict_request(r);
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_pixels.pop_front();
        if (sample_value_o !== e.value)
          report_mismatch($sformatf("sample_value %0h, want %0h", sample_value_o, e.value));
        if (in_range_o !== e.in_range)
          report_mismatch($sformatf("in_range %0b, want %0b", in_range_o, e.in_range));
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("** affine_bilinear_patch_sampler_top: FAILED **");
      $finish;
    end
  end

  initial begin
    model_cfg = '{16384, 0, 0, 16384, 0, 0};
    gen_cfg = model_cfg;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default mapping (rows from rel_y, columns from rel_x), corners, pixel extremes, edge of the patch
    add_load(8'd0, 8'd0, 8'd255);
    add_load(8'd0, 8'd1, 8'd0);
    add_load(8'd1, 8'd0, 8'd128);
    add_load(8'd1, 8'd1, 8'd255);
    add_load(8'd255, 8'd255, 8'd255);
    add_load(8'd254, 8'd254, 8'd0);
    add_load(8'd254, 8'd255, 8'd17);
    add_load(8'd255, 8'd254, 8'd200);
    add_sample(9'd0, 9'd0);
    add_sample(9'd254, 9'd254);
    add_sample(9'd255, 9'd0);
    add_sample(9'd0, 9'd255);
    add_sample(9'd511, 9'd511);
    add_sample(9'd1, 9'd1);
    wait_idle();

    // half-pixel steps give fractions; unused register indexes must do nothing
    write_reg(REG_COEF_XY, 18'd8192);
    write_reg(REG_COEF_YX, 18'd8192);
    write_reg(REG_SPARE_6, 18'h3ffff);
    write_reg(REG_SPARE_7, 18'h15555);
    release_cfg();
    add_sample(9'd1, 9'd1);
    add_sample(9'd3, 9'd0);
    add_sample(9'd509, 9'd509);
    add_sample(9'd510, 9'd0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      random_cfg(4000);
      case (ph)
        1: sender_idle_pct = 71;
        2: stall_pct = 71;
        3: begin sender_idle_pct = 22; stall_pct = 22; end
        default: begin sender_idle_pct = 0; stall_pct = 0; end
      endcase
      pressure_on = (ph == 4);
      random_traffic(110);
      wait_idle();
      sender_idle_pct = 0;
      stall_pct = 0;
    end

    // extreme coefficients and offsets: mostly out of range except at the anchor
    write_reg(REG_COEF_XY, 18'h1ffff);
    write_reg(REG_COEF_XX, 18'h20000);
    write_reg(REG_COEF_YY, 18'h1ffff);
    write_reg(REG_COEF_YX, 18'h20000);
    write_reg(REG_OFFSET_X, 18'h3ff00);
    write_reg(REG_OFFSET_Y, 18'h000fe);
    release_cfg();
    add_sample(9'd0, 9'd0);
    add_sample(9'd1, 9'd0);
    add_sample(9'd0, 9'd1);
    add_sample(9'd511, 9'd511);
    random_traffic(30);
    wait_idle();
    write_reg(REG_OFFSET_X, 18'd0);
    write_reg(REG_OFFSET_Y, 18'd254);
    release_cfg();
    add_sample(9'd0, 9'd0);
    add_sample(9'd1, 9'd1);
    random_traffic(30);
    wait_idle();

    $display("covered %0d loads and %0d samples, %0d of them inside the patch",
             n_loads, n_samples, n_hits);
    $display("idle and stall mixes, a long receiver hold-off, %0d mismatches", errors);
    if (errors == 0)
      $display("** affine_bilinear_patch_sampler_top: PASSED **");
    else
      $display("** affine_bilinear_patch_sampler_top: FAILED **");
    $finish;
  end

endmodule
